[rtl/tis_pkg.sv]
`default_nettype none

package tis_pkg;

   // Ring of injected touches; one slot always stays empty.
   localparam int QUEUE_LEN = 16;
   localparam int IDX_W     = $clog2(QUEUE_LEN);

   // Depths of the command queue and the result queue.
   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
   localparam int RSPQ_DEPTH = 2;
   localparam int RSPQ_PTR_W = $clog2(RSPQ_DEPTH);
   localparam int RSPQ_CNT_W = $clog2(RSPQ_DEPTH + 1);

   // Saturation value of the millisecond counter.
   localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

   // Operation codes of an input word.
   localparam logic [1:0] OP_INJECT = 2'd0;
   localparam logic [1:0] OP_POLL   = 2'd1;
   localparam logic [1:0] OP_TICK   = 2'd2;

   typedef struct packed {
      logic [1:0]         op;
      logic signed [15:0] touch_x;
      logic signed [15:0] touch_y;
      logic [15:0]        hold_ms;
   } req_word_type;

   typedef struct packed {
      logic signed [15:0] point_x;
      logic signed [15:0] point_y;
      logic               pressed;
   } rsp_word_type;

   // Classified command passed from the front end to the back end.
   typedef enum logic [1:0] {
      CMD_INJECT,
      CMD_POLL,
      CMD_TICK
   } cmd_kind_type;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [15:0]        hold_ms;
   } touch_entry_type;

   typedef struct packed {
      cmd_kind_type    kind;
      touch_entry_type touch;
   } cmd_type;

   localparam int ENTRY_W = $bits(touch_entry_type);

endpackage

`default_nettype wire

[rtl/tis_ram.sv]
`default_nettype none

module tis_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port and one registered read port; a read returns the old data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

[rtl/tis_front.sv]
`default_nettype none

module tis_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  tis_pkg::req_word_type req_word,
   output logic                  cmd_valid,
   output tis_pkg::cmd_type      cmd,
   input  logic                  cmd_take
);

   tis_pkg::cmd_type                  cmdq_ff [tis_pkg::CMDQ_DEPTH];
   logic [tis_pkg::CMDQ_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [tis_pkg::CMDQ_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [tis_pkg::CMDQ_CNT_W-1:0]    count_ff, count_in;
   tis_pkg::cmd_type                  new_cmd;
   logic                              keep;
   logic                              accept;
   logic                              enq;

   // Classify the incoming word; unused codes are accepted and dropped.
   always_comb begin
      new_cmd.touch.x       = req_word.touch_x;
      new_cmd.touch.y       = req_word.touch_y;
      new_cmd.touch.hold_ms = req_word.hold_ms;
      new_cmd.kind          = tis_pkg::CMD_TICK;
      keep                  = 1'b1;
      unique case (req_word.op)
         tis_pkg::OP_INJECT: begin
            new_cmd.kind = tis_pkg::CMD_INJECT;
         end
         tis_pkg::OP_POLL: begin
            new_cmd.kind = tis_pkg::CMD_POLL;
         end
         tis_pkg::OP_TICK: begin
            new_cmd.kind = tis_pkg::CMD_TICK;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_full  = (count_ff == tis_pkg::CMDQ_CNT_W'(tis_pkg::CMDQ_DEPTH));
   assign accept    = req_push && !req_full;
   assign enq       = accept && keep;
   assign cmd_valid = (count_ff != '0);
   assign cmd       = cmdq_ff[rd_ptr_ff];

   // Pointer and count updates of the command queue.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (enq) begin
         wr_ptr_in = (wr_ptr_ff == tis_pkg::CMDQ_PTR_W'(tis_pkg::CMDQ_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (cmd_take) begin
         rd_ptr_in = (rd_ptr_ff == tis_pkg::CMDQ_PTR_W'(tis_pkg::CMDQ_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (enq && !cmd_take) begin
         count_in = count_ff + 1'b1;
      end else if (!enq && cmd_take) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (enq) begin
         cmdq_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

`default_nettype wire

[rtl/tis_rspq.sv]
`default_nettype none

module tis_rspq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  tis_pkg::rsp_word_type wr_word,
   output logic                  space,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output tis_pkg::rsp_word_type rsp_word
);

   tis_pkg::rsp_word_type             q_ff [tis_pkg::RSPQ_DEPTH];
   logic [tis_pkg::RSPQ_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [tis_pkg::RSPQ_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [tis_pkg::RSPQ_CNT_W-1:0]    count_ff, count_in;
   logic                              deq;

   assign space     = (count_ff != tis_pkg::RSPQ_CNT_W'(tis_pkg::RSPQ_DEPTH));
   assign rsp_empty = (count_ff == '0);
   assign deq       = rsp_pop && !rsp_empty;
   assign rsp_word  = q_ff[rd_ptr_ff];

   // Pointer and count updates of the result queue.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == tis_pkg::RSPQ_PTR_W'(tis_pkg::RSPQ_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (deq) begin
         rd_ptr_in = (rd_ptr_ff == tis_pkg::RSPQ_PTR_W'(tis_pkg::RSPQ_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !deq) begin
         count_in = count_ff + 1'b1;
      end else if (!wr_en && deq) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         q_ff[wr_ptr_ff] <= wr_word;
      end
   end

endmodule

`default_nettype wire

[rtl/tis_back.sv]
`default_nettype none

module tis_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   input  tis_pkg::cmd_type      cmd,
   output logic                  cmd_take,
   input  logic                  rsp_space,
   output logic                  rsp_valid,
   output tis_pkg::rsp_word_type rsp_word
);

   logic [tis_pkg::IDX_W-1:0]  head_ff, head_in;
   logic [tis_pkg::IDX_W-1:0]  tail_ff, tail_in;
   logic [tis_pkg::IDX_W-1:0]  head_next, tail_next;
   logic                       press_ff, press_in;
   logic                       release_ff, release_in;
   logic [15:0]                elapsed_ff, elapsed_in;
   logic signed [15:0]         latched_x_ff, latched_x_in;
   logic signed [15:0]         latched_y_ff, latched_y_in;
   logic                       bypass_ff, bypass_in;
   tis_pkg::touch_entry_type   byp_data_ff;
   logic [tis_pkg::ENTRY_W-1:0] ram_rdata;
   tis_pkg::touch_entry_type   head_entry;
   logic                       wr_en;
   logic                       pressed;

   // Ring index advance with wrap at the queue length.
   function automatic logic [tis_pkg::IDX_W-1:0] ring_next(
      input logic [tis_pkg::IDX_W-1:0] idx
   );
      logic [tis_pkg::IDX_W-1:0] res;
      if (idx == tis_pkg::IDX_W'(tis_pkg::QUEUE_LEN - 1)) begin
         res = '0;
      end else begin
         res = idx + 1'b1;
      end
      return res;
   endfunction

   // The store is read at the next head index every cycle, so the head
   // entry is ready in the following cycle. A write into the slot being read is
   // forwarded from a bypass register.
   tis_ram #(
      .WIDTH (tis_pkg::ENTRY_W),
      .DEPTH (tis_pkg::QUEUE_LEN)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data (cmd.touch),
      .rd_addr (head_in),
      .rd_data (ram_rdata)
   );

   assign head_entry = bypass_ff ? byp_data_ff : tis_pkg::touch_entry_type'(ram_rdata);
   assign head_next  = ring_next(head_ff);
   assign tail_next  = ring_next(tail_ff);
   assign cmd_take   = cmd_valid && ((cmd.kind != tis_pkg::CMD_POLL) || rsp_space);
   assign bypass_in  = wr_en && (tail_ff == head_in);

   // Carry out one command per cycle, unless a poll waits for result queue space.
   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      press_in     = press_ff;
      release_in   = release_ff;
      elapsed_in   = elapsed_ff;
      latched_x_in = latched_x_ff;
      latched_y_in = latched_y_ff;
      wr_en        = 1'b0;
      rsp_valid    = 1'b0;
      pressed      = 1'b0;
      if (cmd_take) begin
         case (cmd.kind)
            tis_pkg::CMD_INJECT: begin
               // A full ring drops the injection.
               if (tail_next != head_ff) begin
                  wr_en   = 1'b1;
                  tail_in = tail_next;
               end
            end
            tis_pkg::CMD_TICK: begin
               if (elapsed_ff != tis_pkg::ELAPSED_MAX) begin
                  elapsed_in = elapsed_ff + 1'b1;
               end
            end
            tis_pkg::CMD_POLL: begin
               rsp_valid = 1'b1;
               if (press_ff) begin
                  // Holding: pop once the hold time is reached, still pressed.
                  pressed = 1'b1;
                  if (elapsed_ff >= head_entry.hold_ms) begin
                     press_in   = 1'b0;
                     release_in = 1'b1;
                     head_in    = head_next;
                  end
               end else if (release_ff) begin
                  // One released poll is owed after a pop.
                  release_in = 1'b0;
               end else if (head_ff != tail_ff) begin
                  // Start the head touch.
                  latched_x_in = head_entry.x;
                  latched_y_in = head_entry.y;
                  press_in     = 1'b1;
                  elapsed_in   = '0;
                  pressed      = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_word.point_x = latched_x_in;
      rsp_word.point_y = latched_y_in;
      rsp_word.pressed = pressed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         press_ff     <= 1'b0;
         release_ff   <= 1'b0;
         elapsed_ff   <= '0;
         latched_x_ff <= '0;
         latched_y_ff <= '0;
         bypass_ff    <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         press_ff     <= press_in;
         release_ff   <= release_in;
         elapsed_ff   <= elapsed_in;
         latched_x_ff <= latched_x_in;
         latched_y_ff <= latched_y_in;
         bypass_ff    <= bypass_in;
      end
   end

   // Forwarded write data needs no reset.
   always_ff @(posedge clock) begin
      byp_data_ff <= cmd.touch;
   end

endmodule

`default_nettype wire

[rtl/touch_inject_sequencer_core.sv]
// Touch injection sequencer: plays back injected touches as a pointer.
//
// Input channel (req_push / req_full / req_word): each word carries an
// operation code and a touch. Inject words queue a touch (x, y, hold time)
// in a ring that keeps one slot free; an inject into a full ring is lost.
// Tick words advance a saturating millisecond counter. Poll words each
// produce exactly one result word; inject, tick and unused codes produce none.
// Result channel (rsp_empty / rsp_pop / rsp_word): the oldest result is
// shown while rsp_empty is low and leaves when rsp_pop is high.
//
// A front end classifies words into a two-entry command queue; a back end
// executes one command per cycle and writes results into a two-entry
// result queue. Sustained rate is one word per cycle. With empty queues a
// poll is registered in the command queue, then its result in the result
// queue, where the result is shown and can be popped.
// When the result side stalls, the back end halts at the next poll and the
// command queue fills, after which req_full rises; other words keep flowing
// until a poll is blocked. Reset (synchronous) empties both queues and the
// ring and clears the counter and the latched point; no clearing pass.
`default_nettype none

module touch_inject_sequencer_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  tis_pkg::req_word_type req_word,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output tis_pkg::rsp_word_type rsp_word
);

   logic                  cmd_valid;
   logic                  cmd_take;
   tis_pkg::cmd_type      cmd;
   logic                  rsp_space;
   logic                  rsp_valid;
   tis_pkg::rsp_word_type back_word;

   tis_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_word  (req_word),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take)
   );

   tis_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take),
      .rsp_space (rsp_space),
      .rsp_valid (rsp_valid),
      .rsp_word  (back_word)
   );

   tis_rspq u_rspq (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (rsp_valid),
      .wr_word   (back_word),
      .space     (rsp_space),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word)
   );

endmodule

`default_nettype wire

[rtl/tis_checker.sv]
`default_nettype none

module tis_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_full,
   input logic                  rsp_empty,
   input logic                  rsp_pop,
   input tis_pkg::rsp_word_type rsp_word
);

   // Reset leaves no result waiting.
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result waiting after reset");

   // Reset leaves the input side open.
   a_reset_open: assert property (@(posedge clock) reset |=> !req_full)
      else $error("input full after reset");

   // The command queue only fills while results are backed up.
   a_full_backed: assert property (@(posedge clock) disable iff (reset)
      req_full |-> !rsp_empty)
      else $error("input full with no result waiting");

   // A waiting result holds until it is popped.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_word)))
      else $error("waiting result changed before pop");

endmodule

bind touch_inject_sequencer_core tis_checker u_tis_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_word  (rsp_word)
);

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

   // Unused opcode: the block must ignore it.
   localparam logic [1:0] OP_UNUSED = 2'd3;
   // Cycles in which no word moves on either side before the run is declared hung.
   localparam int STALL_LIMIT = 5000;
   localparam int RANDOM_WORDS = 2000;
   // Hold time of the long touch, and the ticks that release it.
   localparam int LONG_HOLD = 40;

   logic                  clock;
   logic                  reset;
   logic                  req_push;
   logic                  req_full;
   tis_pkg::req_word_type req_word;
   logic                  rsp_empty;
   logic                  rsp_pop;
   tis_pkg::rsp_word_type rsp_word;

   touch_inject_sequencer_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_word  (req_word),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word)
   );

   // Shadow copy of the touch ring and pointer state.
   tis_pkg::touch_entry_type ring_store [tis_pkg::QUEUE_LEN];
   int              ring_head;
   int              ring_tail;
   bit              press_held;
   bit              release_owed;
   logic [15:0]     ms_elapsed;
   logic [15:0]     shown_x;
   logic [15:0]     shown_y;

   // Pointer reports still owed by the block, oldest first.
   tis_pkg::rsp_word_type reports_due [$];

   int              errors;
   int              words_taken;
   int              stall_cycles;
   bit              no_idle;

   // One row of the directed stimulus table.
   typedef struct {
      tis_pkg::req_word_type word;
      int                    reps;
      bit                    typed;
      tis_pkg::rsp_word_type want;
   } step_row_type;

   step_row_type    step_rows [$];

   // Clock generation.
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Apply one word to the shadow state; returns whether the word was taken (a poll,
   // a tick or an inject that found room) and the pointer report that it produces, if any.
   task automatic play_touch_word(input tis_pkg::req_word_type w, output bit took,
                                  output bit has_report,
                                  output tis_pkg::rsp_word_type report);
      int nxt;
      took = 1'b0;
      has_report = 1'b0;
      report = '0;
      case (w.op)
         tis_pkg::OP_INJECT: begin
            nxt = (ring_tail + 1) % tis_pkg::QUEUE_LEN;
            // A full ring drops the touch and changes nothing.
            if (nxt != ring_head) begin
               ring_store[ring_tail].x = w.touch_x;
               ring_store[ring_tail].y = w.touch_y;
               ring_store[ring_tail].hold_ms = w.hold_ms;
               ring_tail = nxt;
               took = 1'b1;
            end
         end
         tis_pkg::OP_TICK: begin
            if (ms_elapsed != tis_pkg::ELAPSED_MAX) begin
               ms_elapsed = ms_elapsed + 16'd1;
            end
            took = 1'b1;
         end
         tis_pkg::OP_POLL: begin
            took = 1'b1;
            has_report = 1'b1;
            if (press_held) begin
               // The poll that pops the head still reports pressed.
               if (ms_elapsed >= ring_store[ring_head].hold_ms) begin
                  press_held = 1'b0;
                  release_owed = 1'b1;
                  ring_head = (ring_head + 1) % tis_pkg::QUEUE_LEN;
               end
               report.pressed = 1'b1;
            end else if (release_owed) begin
               release_owed = 1'b0;
               report.pressed = 1'b0;
            end else if (ring_head != ring_tail) begin
               shown_x = ring_store[ring_head].x;
               shown_y = ring_store[ring_head].y;
               press_held = 1'b1;
               ms_elapsed = '0;
               report.pressed = 1'b1;
            end else begin
               report.pressed = 1'b0;
            end
            report.point_x = shown_x;
            report.point_y = shown_y;
         end
         default: begin
         end
      endcase
   endtask

   // Drive one word at the falling edge, idling at random, and hold it until
   // it is accepted. A typed row replaces the predicted report.
   task automatic send_word(input tis_pkg::req_word_type w, input bit typed,
                            input tis_pkg::rsp_word_type want);
      bit                    took;
      bit                    has_report;
      tis_pkg::rsp_word_type report;
      @(negedge clock);
      while (!no_idle && $urandom_range(0, 99) < 15) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (req_full) begin
         @(posedge clock);
      end
      play_touch_word(w, took, has_report, report);
      if (took) begin
         words_taken++;
      end
      if (has_report) begin
         reports_due.push_back(typed ? want : report);
      end
   endtask

   task automatic add_row(input logic [1:0] op, input int x, input int y, input int hold,
                          input int reps, input bit typed, input int px, input int py,
                          input bit pr);
      step_row_type row;
      row.word.op = op;
      row.word.touch_x = x[15:0];
      row.word.touch_y = y[15:0];
      row.word.hold_ms = hold[15:0];
      row.reps = reps;
      row.typed = typed;
      row.want.point_x = px[15:0];
      row.want.point_y = py[15:0];
      row.want.pressed = pr;
      step_rows.push_back(row);
   endtask

   function automatic tis_pkg::req_word_type random_word(input logic [1:0] op);
      tis_pkg::req_word_type w;
      w.op = op;
      w.touch_x = 16'($urandom);
      w.touch_y = 16'($urandom);
      w.hold_ms = 16'($urandom_range(0, 6));
      return w;
   endfunction

   // Stop sending until every owed report has come back.
   task automatic wait_drained();
      @(negedge clock);
      req_push <= 1'b0;
      while (reports_due.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         errors++;
      end
   endtask

   // Result side: pop at random, steadily during the no-idle stretch.
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= no_idle || ($urandom_range(0, 99) >= 15);
      end
   end

   // Compare each popped report with the oldest one owed.
   always @(posedge clock) begin
      tis_pkg::rsp_word_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (reports_due.size() == 0) begin
            $display("%0t: unexpected report, expected none, got x %0d y %0d pressed %0d",
                     $time, rsp_word.point_x, rsp_word.point_y, rsp_word.pressed);
            errors++;
         end else begin
            want = reports_due.pop_front();
            check_field("point_x", want.point_x, rsp_word.point_x);
            check_field("point_y", want.point_y, rsp_word.point_y);
            check_field("pressed", want.pressed, rsp_word.pressed);
         end
      end
   end

   // Watchdog on cycles in which no word moves on either side.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Stimulus: directed table, then random episodes of touch bursts.
   initial begin : stimulus
      step_row_type          row;
      int                    burst;
      int                    mix_len;
      int                    pick;
      int                    episode;
      int                    start_taken;
      tis_pkg::rsp_word_type none;

      none = '0;
      errors = 0;
      words_taken = 0;
      no_idle = 1'b0;
      ring_head = 0;
      ring_tail = 0;
      press_held = 1'b0;
      release_owed = 1'b0;
      ms_elapsed = '0;
      shown_x = '0;
      shown_y = '0;
      reset = 1'b1;
      req_push = 1'b0;
      req_word = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Idle poll after reset, unused code, idle tick.
      add_row(tis_pkg::OP_POLL, 0, 0, 0, 1, 1, 0, 0, 0);
      add_row(OP_UNUSED, -1, -1, 65535, 1, 0, 0, 0, 0);
      add_row(tis_pkg::OP_TICK, 0, 0, 0, 1, 0, 0, 0, 0);
      // Extreme points, zero hold and a long hold.
      add_row(tis_pkg::OP_INJECT, 32767, -32768, 0, 1, 0, 0, 0, 0);
      add_row(tis_pkg::OP_INJECT, -32768, 32767, LONG_HOLD, 1, 0, 0, 0, 0);
      add_row(tis_pkg::OP_INJECT, -1, 0, 1, 1, 0, 0, 0, 0);
      // Zero hold: start, pop on the next poll, then one release.
      add_row(tis_pkg::OP_POLL, 0, 0, 0, 1, 1, 32767, -32768, 1);
      add_row(tis_pkg::OP_POLL, 0, 0, 0, 1, 1, 32767, -32768, 1);
      add_row(tis_pkg::OP_POLL, 0, 0, 0, 1, 1, 32767, -32768, 0);
      add_row(tis_pkg::OP_POLL, 0, 0, 0, 1, 1, -32768, 32767, 1);
      add_row(tis_pkg::OP_TICK, 0, 0, 0, 1, 0, 0, 0, 0);
      add_row(tis_pkg::OP_POLL, 0, 0, 0, 1, 1, -32768, 32767, 1);
      // The long hold is released once the counter reaches it.
      add_row(tis_pkg::OP_TICK, 0, 0, 0, LONG_HOLD, 0, 0, 0, 0);
      add_row(tis_pkg::OP_POLL, 0, 0, 0, 1, 1, -32768, 32767, 1);
      add_row(tis_pkg::OP_POLL, 0, 0, 0, 1, 1, -32768, 32767, 0);
      add_row(tis_pkg::OP_POLL, 0, 0, 0, 1, 1, -1, 0, 1);
      add_row(tis_pkg::OP_TICK, 0, 0, 0, 1, 0, 0, 0, 0);
      add_row(tis_pkg::OP_POLL, 0, 0, 0, 1, 1, -1, 0, 1);
      add_row(tis_pkg::OP_POLL, 0, 0, 0, 1, 1, -1, 0, 0);
      add_row(tis_pkg::OP_POLL, 0, 0, 0, 1, 1, -1, 0, 0);
      // Ticks while idle must be cleared when the next touch starts.
      add_row(tis_pkg::OP_INJECT, 100, -100, 2, 1, 0, 0, 0, 0);
      add_row(tis_pkg::OP_TICK, 0, 0, 0, 3, 0, 0, 0, 0);
      add_row(tis_pkg::OP_POLL, 0, 0, 0, 1, 1, 100, -100, 1);
      add_row(tis_pkg::OP_POLL, 0, 0, 0, 1, 0, 0, 0, 0);

      foreach (step_rows[i]) begin
         row = step_rows[i];
         repeat (row.reps) begin
            send_word(row.word, row.typed, row.want);
         end
      end
      wait_drained();

      // Random episodes: a burst of injects, sometimes overfilling the ring,
      // then a mix of polls, ticks, injects and unused codes.
      start_taken = words_taken;
      episode = 0;
      while (words_taken - start_taken < RANDOM_WORDS) begin
         no_idle = (words_taken - start_taken >= 600) && (words_taken - start_taken < 900);
         burst = $urandom_range(1, 18);
         repeat (burst) begin
            send_word(random_word(tis_pkg::OP_INJECT), 1'b0, none);
         end
         mix_len = $urandom_range(10, 50);
         repeat (mix_len) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
               send_word(random_word(tis_pkg::OP_POLL), 1'b0, none);
            end else if (pick < 75) begin
               send_word(random_word(tis_pkg::OP_TICK), 1'b0, none);
            end else if (pick < 95) begin
               send_word(random_word(tis_pkg::OP_INJECT), 1'b0, none);
            end else begin
               send_word(random_word(OP_UNUSED), 1'b0, none);
            end
         end
         episode++;
         if (episode % 10 == 0) begin
            wait_drained();
         end
      end
      no_idle = 1'b0;

      // Let every owed report come back, then a few quiet cycles.
      wait_drained();
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[files.f]
rtl/tis_pkg.sv
rtl/tis_ram.sv
rtl/tis_front.sv
rtl/tis_rspq.sv
rtl/tis_back.sv
rtl/touch_inject_sequencer_core.sv
rtl/tis_checker.sv
tb/tb_top.sv
